>>> design/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
`default_nettype none

package rc4_pkg;

	// Width of the register bus address: two 64-bit registers at byte offsets 0 and 8.
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 64;

	// Input transaction payload.
	typedef struct packed {
		logic       cmd;
		logic [7:0] data_in;
		logic       last_in;
	} in_item_t;

	// Result transaction payload.
	typedef struct packed {
		logic [7:0] data_out;
		logic       last_out;
	} out_item_t;

	// Command codes carried in the cmd field.
	localparam logic CMD_INIT = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	// Read address sources for the permutation memory.
	typedef enum logic [1:0] {
		RD_I_NEXT = 2'd0,
		RD_N      = 2'd1,
		RD_J_NEXT = 2'd2,
		RD_SUM    = 2'd3
	} rd_sel_t;

	// Write address and data sources for the permutation memory.
	typedef enum logic [1:0] {
		WR_FILL = 2'd0,
		WR_N    = 2'd1,
		WR_I    = 2'd2,
		WR_J    = 2'd3
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    cnt_clr;
		logic    cnt_inc;
		logic    ld_in;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    ld_a;
		logic    ld_j;
		logic    key_mode;
		logic    ld_b;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    ld_out;
		logic    clr_idx;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> design/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher: key registers, controller and datapath.
// Data byte: D_J, D_SI and D_SJ follow acceptance and the input stalls; D_SJ loads the output register
//   once it is free, as set by the single read and write port of the 256-entry permutation memory.
// Init command: a fill pass restores the identity, then each key schedule entry steps through KS_RN,
//   KS_RJ, KS_WN and KS_WJ before the next transaction is taken; it gives no result.
// Reset: keys and indices clear at once; a pass over every entry then writes the identity
//   permutation while the input stays stalled. Register writes are taken throughout.
`default_nettype none

module rc4_stream_cipher (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Configuration port.
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rc4_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [rc4_pkg::PDATA_W-1:0]  pwdata,
	output logic      [rc4_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	// Input channel.
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire rc4_pkg::in_item_t            in_data,
	// Output channel.
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output rc4_pkg::out_item_t                out_data
);

	logic [rc4_pkg::PDATA_W-1:0] key_low;
	logic [rc4_pkg::PDATA_W-1:0] key_high;
	rc4_pkg::ctrl_cmd_t          cmd;
	rc4_pkg::dp_status_t         status;

	// The key registers are read only when an init command runs the schedule, so a
	// new key takes effect at the next init transaction.
	rc4_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.key_low  (key_low),
		.key_high (key_high)
	);

	// The controller takes one transaction at a time and steps the datapath through
	// the fill pass, the key schedule or the states D_J, D_SI and D_SJ of a data byte.
	rc4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.cmd),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath owns the permutation memory and the result register, so a
	// finished byte can wait downstream while the next transaction is accepted.
	rc4_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.key_low   (key_low),
		.key_high  (key_high),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> design/rc4_regs.sv
// Key register file behind the APB-style configuration port.
`default_nettype none

module rc4_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rc4_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [rc4_pkg::PDATA_W-1:0]  pwdata,
	output logic      [rc4_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	output logic      [rc4_pkg::PDATA_W-1:0]  key_low,
	output logic      [rc4_pkg::PDATA_W-1:0]  key_high
);

	logic [rc4_pkg::PDATA_W-1:0] key_low_q;
	logic [rc4_pkg::PDATA_W-1:0] key_high_q;
	logic                        wr_fire;

	// Bit 3 of the byte address selects the register; the space holds only the two keys.
	assign wr_fire = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (wr_fire) begin
			if (paddr[3]) begin
				key_high_q <= pwdata;
			end else begin
				key_low_q <= pwdata;
			end
		end
	end

	assign prdata   = paddr[3] ? key_high_q : key_low_q;
	assign pready   = 1'b1;
	assign key_low  = key_low_q;
	assign key_high = key_high_q;

endmodule

`default_nettype wire

>>> design/rc4_dpath.sv
// Datapath: permutation memory, indices, key byte selection and output register.
`default_nettype none

module rc4_dpath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rc4_pkg::ctrl_cmd_t          cmd,
	output rc4_pkg::dp_status_t              status,
	input  wire rc4_pkg::in_item_t           in_data,
	input  wire logic [rc4_pkg::PDATA_W-1:0] key_low,
	input  wire logic [rc4_pkg::PDATA_W-1:0] key_high,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output rc4_pkg::out_item_t               out_data
);

	logic [7:0] perm_mem [256];
	logic [7:0] rd_q;
	logic [7:0] i_q;
	logic [7:0] j_q;
	logic [7:0] n_q;
	logic [7:0] a_q;
	logic [7:0] b_q;
	logic [7:0] k_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       out_valid_q;
	rc4_pkg::out_item_t out_q;

	logic [7:0] i_next;
	logic [7:0] key_byte;
	logic [7:0] key_term;
	logic [7:0] j_add;
	logic [7:0] sum_ab;
	logic [7:0] rd_addr;
	logic [7:0] wr_addr;
	logic [7:0] wr_data;
	logic [7:0] ks;
	logic [rc4_pkg::PDATA_W-1:0] key_word;

	assign i_next   = i_q + 8'd1;
	assign key_word = n_q[3] ? key_high : key_low;
	assign key_byte = key_word[{n_q[2:0], 3'b000} +: 8];
	assign key_term = cmd.key_mode ? key_byte : 8'd0;
	assign j_add    = j_q + rd_q + key_term;
	assign sum_ab   = a_q + rd_q;

	always_comb begin
		case (cmd.rd_sel)
			rc4_pkg::RD_I_NEXT: rd_addr = i_next;
			rc4_pkg::RD_N:      rd_addr = n_q;
			rc4_pkg::RD_J_NEXT: rd_addr = j_add;
			rc4_pkg::RD_SUM:    rd_addr = sum_ab;
			default:            rd_addr = n_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			rc4_pkg::WR_FILL: begin
				wr_addr = n_q;
				wr_data = n_q;
			end
			rc4_pkg::WR_N: begin
				wr_addr = n_q;
				wr_data = rd_q;
			end
			rc4_pkg::WR_I: begin
				wr_addr = i_q;
				wr_data = rd_q;
			end
			rc4_pkg::WR_J: begin
				wr_addr = j_q;
				wr_data = a_q;
			end
			default: begin
				wr_addr = n_q;
				wr_data = n_q;
			end
		endcase
	end

	// The keystream read is issued in the same cycle that S[i] is written, so it sees
	// the table before the swap; the two swapped entries are forwarded instead.
	always_comb begin
		if (k_q == j_q) begin
			ks = a_q;
		end else if (k_q == i_q) begin
			ks = b_q;
		end else begin
			ks = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			perm_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= perm_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			data_q <= in_data.data_in;
			last_q <= in_data.last_in;
		end
		if (cmd.ld_a) begin
			a_q <= rd_q;
		end
		if (cmd.ld_b) begin
			b_q <= rd_q;
			k_q <= sum_ab;
		end
		if (cmd.ld_out) begin
			out_q.data_out <= data_q ^ ks;
			out_q.last_out <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_idx) begin
				i_q <= '0;
				j_q <= '0;
			end else begin
				if (cmd.ld_in) begin
					i_q <= i_next;
				end
				if (cmd.ld_j) begin
					j_q <= j_add;
				end
			end
			if (cmd.cnt_clr) begin
				n_q <= '0;
			end else if (cmd.cnt_inc) begin
				n_q <= n_q + 8'd1;
			end
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.cnt_last = (n_q == 8'hFF);
	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

	// A new result must never overwrite one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> status.out_free)
		else $error("result register loaded while a result is pending");

	// Clearing the indices leaves both at zero.
	a_idx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_idx |=> (i_q == 8'd0) && (j_q == 8'd0))
		else $error("indices not cleared");

endmodule

`default_nettype wire

>>> design/rc4_ctrl.sv
// Controller state machine sequencing table fill, key schedule and data bytes.
`default_nettype none

module rc4_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_cmd,
	output logic                    in_stall,
	input  wire rc4_pkg::dp_status_t status,
	output rc4_pkg::ctrl_cmd_t      cmd
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_FILL  = 10'b0000000010,
		ST_KS_RN = 10'b0000000100,
		ST_KS_RJ = 10'b0000001000,
		ST_KS_WN = 10'b0000010000,
		ST_KS_WJ = 10'b0000100000,
		ST_D_J   = 10'b0001000000,
		ST_D_SI  = 10'b0010000000,
		ST_D_SJ  = 10'b0100000000,
		ST_BOOT  = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rd_sel     = rc4_pkg::RD_N;
		cmd.wr_sel     = rc4_pkg::WR_FILL;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == rc4_pkg::CMD_DATA) begin
						cmd.ld_in  = 1'b1;
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = rc4_pkg::RD_I_NEXT;
						state_d    = ST_D_J;
					end else begin
						cmd.cnt_clr = 1'b1;
						state_d     = ST_FILL;
					end
				end
			end
			// After reset the table is only brought back to the identity; no schedule runs.
			ST_BOOT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = rc4_pkg::WR_FILL;
				cmd.cnt_inc = 1'b1;
				if (status.cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_FILL: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = rc4_pkg::WR_FILL;
				cmd.cnt_inc = 1'b1;
				if (status.cnt_last) begin
					cmd.clr_idx = 1'b1;
					state_d     = ST_KS_RN;
				end
			end
			ST_KS_RN: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rc4_pkg::RD_N;
				state_d    = ST_KS_RJ;
			end
			ST_KS_RJ: begin
				cmd.ld_a     = 1'b1;
				cmd.ld_j     = 1'b1;
				cmd.key_mode = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = rc4_pkg::RD_J_NEXT;
				state_d      = ST_KS_WN;
			end
			ST_KS_WN: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = rc4_pkg::WR_N;
				state_d    = ST_KS_WJ;
			end
			ST_KS_WJ: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = rc4_pkg::WR_J;
				cmd.cnt_inc = 1'b1;
				if (status.cnt_last) begin
					cmd.clr_idx = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					state_d = ST_KS_RN;
				end
			end
			ST_D_J: begin
				cmd.ld_a   = 1'b1;
				cmd.ld_j   = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rc4_pkg::RD_J_NEXT;
				state_d    = ST_D_SI;
			end
			ST_D_SI: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = rc4_pkg::WR_I;
				cmd.ld_b   = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rc4_pkg::RD_SUM;
				state_d    = ST_D_SJ;
			end
			ST_D_SJ: begin
				// Rewriting S[j] while the result waits is harmless.
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = rc4_pkg::WR_J;
				if (status.out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// An accepted data byte always starts the swap sequence.
	a_data_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && in_cmd == rc4_pkg::CMD_DATA) |=> state_q == ST_D_J)
		else $error("data byte did not start its sequence");

	// The key schedule ends after its last entry and returns to idle.
	a_ks_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KS_WJ && status.cnt_last) |=> state_q == ST_IDLE)
		else $error("key schedule did not finish after the last entry");

endmodule

`default_nettype wire
